// ===== rtl/bcg_pkg.sv =====
`default_nettype none

package bcg_pkg;

    localparam int CH_W      = 8;
    localparam int RGB_W     = 3 * CH_W;
    localparam int COORD_W   = 12;
    localparam int SIZE_W    = 13;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CH    = 3;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // |b - a| * pos fits here; quotient never exceeds one channel
    localparam int PROD_W   = CH_W + COORD_W;
    localparam int Q_STEPS  = CH_W;
    localparam int LERP_LAT = Q_STEPS + 2;
    localparam int PIPE_LAT = 2 * LERP_LAT;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOP_LEFT     = 3'd0,
        REG_TOP_RIGHT    = 3'd1,
        REG_BOTTOM_LEFT  = 3'd2,
        REG_BOTTOM_RIGHT = 3'd3,
        REG_FILL_WIDTH   = 3'd4,
        REG_FILL_HEIGHT  = 3'd5
    } cfg_reg_t;

    localparam logic [RGB_W-1:0]  TOP_LEFT_RST     = 24'hFF0000;
    localparam logic [RGB_W-1:0]  TOP_RIGHT_RST    = 24'h0000FF;
    localparam logic [RGB_W-1:0]  BOTTOM_LEFT_RST  = 24'hFFFF00;
    localparam logic [RGB_W-1:0]  BOTTOM_RIGHT_RST = 24'h00FF00;
    localparam logic [SIZE_W-1:0] FILL_WIDTH_RST   = 13'd1080;
    localparam logic [SIZE_W-1:0] FILL_HEIGHT_RST  = 13'd720;

endpackage

`default_nettype wire

// ===== rtl/bcg_pixel_if.sv =====
`default_nettype none

interface bcg_pixel_if;
    import bcg_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/bcg_color_if.sv =====
`default_nettype none

interface bcg_color_if;
    import bcg_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            outside;

    modport source (output valid, output red, output green, output blue, output outside,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input outside,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/bilinear_color_gradient_top.sv =====
`default_nettype none

// Four-corner bilinear color fill. Each request carries a pixel coordinate and
// returns that pixel's 8-bit RGB color; coordinates at or beyond the fill size
// give black with outside set. One pixel is taken every clock cycle unless
// stalled, through two chained interpolation pipelines of 10 stages, one
// quotient bit per divide stage; the whole pipeline holds while a finished
// result is not taken. The user must write corner colors and size through
// the cfg port only while no request is in flight; the block does not enforce
// it. Sizes above 4096 saturate, a zero size makes every pixel outside.
module bilinear_color_gradient_top (
    input  logic                           clk,
    input  logic                           rst_n,
    bcg_pixel_if.sink                      pixel_in,
    bcg_color_if.source                    color_out,
    input  logic                           cfg_we,
    input  logic [bcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcg_pkg::RGB_W-1:0]      cfg_wdata
);
    import bcg_pkg::*;

    logic [RGB_W-1:0]  top_left_reg, top_right_reg, bottom_left_reg, bottom_right_reg;
    logic [SIZE_W-1:0] fill_width_reg, fill_height_reg;

    logic [SIZE_W-1:0]  w_sat, h_sat;
    logic [COORD_W-1:0] span_w_next, span_h_next;
    logic [COORD_W-1:0] span_w_reg, span_h_reg;

    logic                pipe_en;
    logic                outside_in;
    logic [PIPE_LAT-1:0] valid_reg;
    logic [PIPE_LAT-1:0] outside_reg;
    logic [COORD_W-1:0]  x_pipe_reg [0:LERP_LAT-1];

    logic [CH_W-1:0] left_c  [0:NUM_CH-1];
    logic [CH_W-1:0] right_c [0:NUM_CH-1];
    logic [CH_W-1:0] color_c [0:NUM_CH-1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_left_reg     <= TOP_LEFT_RST;
            top_right_reg    <= TOP_RIGHT_RST;
            bottom_left_reg  <= BOTTOM_LEFT_RST;
            bottom_right_reg <= BOTTOM_RIGHT_RST;
            fill_width_reg   <= FILL_WIDTH_RST;
            fill_height_reg  <= FILL_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TOP_LEFT:     top_left_reg     <= cfg_wdata;
                REG_TOP_RIGHT:    top_right_reg    <= cfg_wdata;
                REG_BOTTOM_LEFT:  bottom_left_reg  <= cfg_wdata;
                REG_BOTTOM_RIGHT: bottom_right_reg <= cfg_wdata;
                REG_FILL_WIDTH:   fill_width_reg   <= cfg_wdata[SIZE_W-1:0];
                REG_FILL_HEIGHT:  fill_height_reg  <= cfg_wdata[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign w_sat = (fill_width_reg > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : fill_width_reg;
    assign h_sat = (fill_height_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT)
                                                            : fill_height_reg;

    // a one-wide span only ever sees pos 0, so divisor 1 gives the edge value
    assign span_w_next = (w_sat > SIZE_W'(1)) ? COORD_W'(w_sat - SIZE_W'(1)) : COORD_W'(1);
    assign span_h_next = (h_sat > SIZE_W'(1)) ? COORD_W'(h_sat - SIZE_W'(1)) : COORD_W'(1);

    // first divide step is one stage after entry, so a registered span is in time
    always_ff @(posedge clk)
    begin
        span_w_reg <= span_w_next;
        span_h_reg <= span_h_next;
    end

    assign outside_in = ({1'b0, pixel_in.pixel_x} >= w_sat) ||
                        ({1'b0, pixel_in.pixel_y} >= h_sat);

    assign pipe_en        = !valid_reg[PIPE_LAT-1] || color_out.ready;
    assign pixel_in.ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (pipe_en)
        begin
            valid_reg <= {valid_reg[PIPE_LAT-2:0], pixel_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            outside_reg   <= {outside_reg[PIPE_LAT-2:0], outside_in};
            x_pipe_reg[0] <= pixel_in.pixel_x;
            for (int i = 1; i < LERP_LAT; i++)
            begin
                x_pipe_reg[i] <= x_pipe_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < NUM_CH; k++)
    begin : g_ch
        localparam int HI = RGB_W - 1 - CH_W * k;

        bcg_lerp u_left (
            .clk  (clk),
            .en   (pipe_en),
            .a    (top_left_reg[HI -: CH_W]),
            .b    (bottom_left_reg[HI -: CH_W]),
            .pos  (pixel_in.pixel_y),
            .span (span_h_reg),
            .res  (left_c[k])
        );

        bcg_lerp u_right (
            .clk  (clk),
            .en   (pipe_en),
            .a    (top_right_reg[HI -: CH_W]),
            .b    (bottom_right_reg[HI -: CH_W]),
            .pos  (pixel_in.pixel_y),
            .span (span_h_reg),
            .res  (right_c[k])
        );

        bcg_lerp u_row (
            .clk  (clk),
            .en   (pipe_en),
            .a    (left_c[k]),
            .b    (right_c[k]),
            .pos  (x_pipe_reg[LERP_LAT-1]),
            .span (span_w_reg),
            .res  (color_c[k])
        );
    end

    assign color_out.valid   = valid_reg[PIPE_LAT-1];
    assign color_out.outside = outside_reg[PIPE_LAT-1];
    assign color_out.red     = outside_reg[PIPE_LAT-1] ? '0 : color_c[0];
    assign color_out.green   = outside_reg[PIPE_LAT-1] ? '0 : color_c[1];
    assign color_out.blue    = outside_reg[PIPE_LAT-1] ? '0 : color_c[2];

    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (color_out.valid && !color_out.ready) |-> !pixel_in.ready)
        else $error("request taken while result stalled");

    a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");

    a_x_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LERP_LAT-1] && !outside_reg[LERP_LAT-1])
            |-> (x_pipe_reg[LERP_LAT-1] <= span_w_reg))
        else $error("inside pixel beyond row span");

endmodule

`default_nettype wire

// ===== rtl/bcg_lerp.sv =====
`default_nettype none

// a + trunc((b - a) * pos / span), one quotient bit per divide stage.
// Needs pos <= span and span >= 1; stages advance only while en is high.
module bcg_lerp (
    input  logic                         clk,
    input  logic                         en,
    input  logic [bcg_pkg::CH_W-1:0]     a,
    input  logic [bcg_pkg::CH_W-1:0]     b,
    input  logic [bcg_pkg::COORD_W-1:0]  pos,
    input  logic [bcg_pkg::COORD_W-1:0]  span,
    output logic [bcg_pkg::CH_W-1:0]     res
);
    import bcg_pkg::*;

    logic signed [CH_W:0] diff;
    logic        [CH_W:0] diff_neg;
    logic [CH_W-1:0]      diff_mag;
    logic [PROD_W-1:0]    prod;

    logic [PROD_W-1:0] rem_reg  [0:Q_STEPS-1];
    logic [CH_W-1:0]   q_reg    [0:Q_STEPS];
    logic              neg_reg  [0:Q_STEPS];
    logic [CH_W-1:0]   base_reg [0:Q_STEPS];
    logic [CH_W-1:0]   q_signed;
    logic [CH_W-1:0]   res_reg;

    assign diff     = $signed({1'b0, b}) - $signed({1'b0, a});
    assign diff_neg = -diff;
    assign diff_mag = diff[CH_W] ? diff_neg[CH_W-1:0] : diff[CH_W-1:0];
    assign prod     = PROD_W'(diff_mag) * PROD_W'(pos);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= prod;
            q_reg[0]    <= '0;
            neg_reg[0]  <= diff[CH_W];
            base_reg[0] <= a;
        end
    end

    // restoring division, quotient MSB first
    for (genvar j = 0; j < Q_STEPS; j++)
    begin : g_step
        localparam int SH = Q_STEPS - 1 - j;
        logic [PROD_W-1:0] dvs;
        logic              ge;

        assign dvs = PROD_W'(span) << SH;
        assign ge  = rem_reg[j] >= dvs;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j+1]    <= {q_reg[j][CH_W-2:0], ge};
                neg_reg[j+1]  <= neg_reg[j];
                base_reg[j+1] <= base_reg[j];
            end
        end

        if (j < Q_STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= ge ? rem_reg[j] - dvs : rem_reg[j];
                end
            end
        end
    end

    assign q_signed = neg_reg[Q_STEPS] ? -q_reg[Q_STEPS] : q_reg[Q_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= base_reg[Q_STEPS] + q_signed;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== tb/bcg_gradient_checker.sv =====
module bcg_gradient_checker
    import bcg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bcg_pixel_if                 pixel_in,
    bcg_color_if                 color_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RGB_W-1:0]     cfg_wdata,
    output int                   mismatches,
    output int                   awaiting,
    output int                   outside_hits
);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            outside;
    } color_t;

    logic [RGB_W-1:0]  tl_rgb;
    logic [RGB_W-1:0]  tr_rgb;
    logic [RGB_W-1:0]  bl_rgb;
    logic [RGB_W-1:0]  br_rgb;
    logic [SIZE_W-1:0] area_w;
    logic [SIZE_W-1:0] area_h;

    color_t expected_colors[$];
    int     fail_tally;
    int     outside_tally;

    // channel 0 is red in the top byte
    function automatic int corner_level(logic [RGB_W-1:0] rgb, int k);
        return int'(rgb[(NUM_CH-1-k)*CH_W +: CH_W]);
    endfunction

    // a + trunc((b - a) * pos / span), signed division truncates toward zero
    function automatic int blend(int a, int b, int pos, int span);
        if (span <= 0)
            return a;
        return a + ((b - a) * pos) / span;
    endfunction

    function automatic color_t gradient_color(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
        int               w;
        int               h;
        int               lft;
        int               rgt;
        int               mix;
        logic [RGB_W-1:0] levels;
        color_t           c;
        w = (area_w > MAX_WIDTH) ? MAX_WIDTH : int'(area_w);
        h = (area_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(area_h);
        c = '0;
        if (int'(px) >= w || int'(py) >= h)
        begin
            c.outside = 1'b1;
            return c;
        end
        levels = '0;
        for (int k = 0; k < NUM_CH; k++)
        begin
            lft = blend(corner_level(tl_rgb, k), corner_level(bl_rgb, k), int'(py), h - 1);
            rgt = blend(corner_level(tr_rgb, k), corner_level(br_rgb, k), int'(py), h - 1);
            mix = blend(lft, rgt, int'(px), w - 1);
            levels[(NUM_CH-1-k)*CH_W +: CH_W] = mix[CH_W-1:0];
        end
        {c.red, c.green, c.blue} = levels;
        return c;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        color_t got;
        color_t want;
        if (!rst_n)
        begin
            tl_rgb <= TOP_LEFT_RST;
            tr_rgb <= TOP_RIGHT_RST;
            bl_rgb <= BOTTOM_LEFT_RST;
            br_rgb <= BOTTOM_RIGHT_RST;
            area_w <= FILL_WIDTH_RST;
            area_h <= FILL_HEIGHT_RST;
            expected_colors.delete();
            fail_tally    = 0;
            outside_tally = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TOP_LEFT:     tl_rgb <= cfg_wdata;
                    REG_TOP_RIGHT:    tr_rgb <= cfg_wdata;
                    REG_BOTTOM_LEFT:  bl_rgb <= cfg_wdata;
                    REG_BOTTOM_RIGHT: br_rgb <= cfg_wdata;
                    REG_FILL_WIDTH:   area_w <= cfg_wdata[SIZE_W-1:0];
                    REG_FILL_HEIGHT:  area_h <= cfg_wdata[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (pixel_in.valid && pixel_in.ready)
                expected_colors.push_back(gradient_color(pixel_in.pixel_x, pixel_in.pixel_y));
            if (color_out.valid && color_out.ready)
            begin
                got = {color_out.red, color_out.green, color_out.blue, color_out.outside};
                if (expected_colors.size() == 0)
                begin
                    $error("color result with no pixel request waiting");
                    fail_tally++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    check_field("red", int'(want.red), int'(got.red));
                    check_field("green", int'(want.green), int'(got.green));
                    check_field("blue", int'(want.blue), int'(got.blue));
                    check_field("outside", int'(want.outside), int'(got.outside));
                    if (got.outside)
                        outside_tally++;
                end
            end
        end
        mismatches   <= fail_tally;
        awaiting     <= expected_colors.size();
        outside_hits <= outside_tally;
    end

endmodule

// ===== tb/tb_bilinear_color_gradient_top.sv =====
module tb_bilinear_color_gradient_top;
    import bcg_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_PIXELS  = 62;
    localparam int COORD_MAX     = (1 << COORD_W) - 1;
    localparam int SIZE_MAX      = (1 << SIZE_W) - 1;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 px_valid  = 1'b0;
    logic [COORD_W-1:0]   px_x      = '0;
    logic [COORD_W-1:0]   px_y      = '0;
    logic                 col_ready = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_TOP_LEFT;
    logic [RGB_W-1:0]     cfg_wdata = '0;
    logic                 calm      = 1'b0;

    int unsigned stall_left    = 0;
    int          idle_cycles   = 0;
    int          area_w        = int'(FILL_WIDTH_RST);
    int          area_h        = int'(FILL_HEIGHT_RST);
    int          pixels_sent   = 0;
    int          settings_made = 0;
    int          mismatches;
    int          awaiting;
    int          outside_hits;

    bcg_pixel_if pixel_ch ();
    bcg_color_if color_ch ();

    assign pixel_ch.valid   = px_valid;
    assign pixel_ch.pixel_x = px_x;
    assign pixel_ch.pixel_y = px_y;
    assign color_ch.ready   = col_ready;

    bilinear_color_gradient_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pixel_ch),
        .color_out (color_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    bcg_gradient_checker color_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_in     (pixel_ch),
        .color_out    (color_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .awaiting     (awaiting),
        .outside_hits (outside_hits)
    );

    always #2 clk = ~clk;

    // sink side back-pressure: mostly short stalls, now and then a long one
    always @(posedge clk)
    begin : sink_pace
        int unsigned roll;
        if (stall_left != 0)
        begin
            col_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (calm)
            col_ready <= 1'b1;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
                col_ready <= 1'b1;
            else
            begin
                col_ready  <= 1'b0;
                stall_left <= (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixel_ch.valid && pixel_ch.ready) || (color_ch.valid && color_ch.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // biased toward the area edges, with some requests beyond them
    function automatic int pick_coord(int span);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (span == 0 || roll < 10)
            return $urandom_range(0, COORD_MAX);
        if (roll < 25)
        begin
            case ($urandom_range(0, 2))
                0:       return 0;
                1:       return span - 1;
                default: return (span > COORD_MAX) ? COORD_MAX : span;
            endcase
        end
        if (roll < 35 && span <= COORD_MAX)
            return $urandom_range(span, COORD_MAX);
        return $urandom_range(0, span - 1);
    endfunction

    function automatic logic [RGB_W-1:0] pick_corner();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return '0;
        if (roll < 24)
            return '1;
        return RGB_W'($urandom);
    endfunction

    // small areas dominate so edges and outside pixels come up often
    function automatic int pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(1, 64);
        if (roll < 75)
            return $urandom_range(65, MAX_WIDTH);
        if (roll < 85)
            return 1;
        if (roll < 90)
            return 0;
        return $urandom_range(MAX_WIDTH + 1, SIZE_MAX);
    endfunction

    task automatic send_pixel(input int x, input int y);
        int unsigned gap;
        px_valid <= 1'b1;
        px_x     <= COORD_W'(x);
        px_y     <= COORD_W'(y);
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
        pixels_sent++;
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            px_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every request has come back and the pipeline is empty
    task automatic settle();
        px_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaiting != 0);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RGB_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic set_fill(input logic [RGB_W-1:0] tl, input logic [RGB_W-1:0] tr,
                            input logic [RGB_W-1:0] bl, input logic [RGB_W-1:0] br,
                            input int w, input int h, input bit spare);
        logic [RGB_W-1:0] noise;
        write_reg(REG_TOP_LEFT, tl);
        write_reg(REG_TOP_RIGHT, tr);
        write_reg(REG_BOTTOM_LEFT, bl);
        write_reg(REG_BOTTOM_RIGHT, br);
        // unused upper data bits carry junk, size registers must ignore them
        noise = RGB_W'($urandom);
        write_reg(REG_FILL_WIDTH, {noise[RGB_W-1:SIZE_W], w[SIZE_W-1:0]});
        noise = RGB_W'($urandom);
        write_reg(REG_FILL_HEIGHT, {noise[RGB_W-1:SIZE_W], h[SIZE_W-1:0]});
        if (spare)
        begin
            write_reg(REG_SPARE_LO, RGB_W'($urandom));
            write_reg(REG_SPARE_HI, RGB_W'($urandom));
        end
        cfg_we <= 1'b0;
        area_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
        area_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
        settings_made++;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset colors and size: corners, last row/column and just beyond
        send_pixel(0, 0);
        send_pixel(area_w - 1, 0);
        send_pixel(0, area_h - 1);
        send_pixel(area_w - 1, area_h - 1);
        send_pixel(area_w, 5);
        send_pixel(5, area_h);

        settle();
        set_fill('0, '1, '1, 24'h00FF80, MAX_WIDTH, MAX_HEIGHT, 1'b0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(0, COORD_MAX);
        send_pixel(COORD_MAX, 0);
        send_pixel(2048, 1000);

        // single pixel, single column, single row
        settle();
        set_fill(24'h123456, 24'hABCDEF, 24'h0F0F0F, 24'hF0F0F0, 1, 1, 1'b0);
        send_pixel(0, 0);
        send_pixel(1, 0);
        send_pixel(0, 1);
        settle();
        set_fill(24'h20FF00, 24'hFF0000, 24'h00FF20, 24'h0000FF, 1, 50, 1'b0);
        send_pixel(0, 49);
        send_pixel(0, 20);
        settle();
        set_fill(24'h20FF00, 24'hFF0000, 24'h00FF20, 24'h0000FF, 50, 1, 1'b0);
        send_pixel(49, 0);
        send_pixel(25, 0);

        // zero width, then zero height
        settle();
        set_fill('1, '1, '1, '1, 0, 10, 1'b0);
        send_pixel(0, 0);
        settle();
        set_fill('1, '1, '1, '1, 10, 0, 1'b0);
        send_pixel(3, 0);

        // oversize saturates; writes to unused indexes go nowhere
        settle();
        set_fill(24'hFF00FF, 24'h00FFFF, 24'h808080, 24'h010203, SIZE_MAX, 5000, 1'b1);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(COORD_MAX, 0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            calm <= ($urandom_range(0, 3) == 0);
            set_fill(pick_corner(), pick_corner(), pick_corner(), pick_corner(),
                     pick_size(), pick_size(), $urandom_range(0, 2) == 0);
            for (int i = 0; i < PHASE_PIXELS; i++)
                send_pixel(pick_coord(area_w), pick_coord(area_h));
        end

        settle();
        $display("Covered %0d pixel requests under %0d fill settings (edges, single row/column,",
                 pixels_sent, settings_made);
        $display("zero and oversize areas); %0d results were outside the area", outside_hits);
        if (mismatches == 0 && awaiting == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
